FILE: hw/rtl/bcks64_pkg.sv
package bcks64_pkg;

	localparam int unsigned ROUNDS      = 12;
	localparam int unsigned NUM_SUBKEYS = 2 * ROUNDS + 2;
	localparam int unsigned WORD_W      = 64;
	localparam int unsigned IDX_W       = 6;
	localparam int unsigned ROT_W       = 6;
	localparam int unsigned FIXED_ROT   = 3;
	localparam int unsigned S_DATA_W    = 2 * WORD_W;
	localparam int unsigned M_DATA_W    = ((IDX_W + WORD_W + 7) / 8) * 8;
	localparam int unsigned M_PAD_W     = M_DATA_W - IDX_W - WORD_W;

	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_SUBKEYS - 1);
	localparam logic [WORD_W-1:0] SEED_P    = 64'hb7e1_5162_8aed_2a6b;
	localparam logic [WORD_W-1:0] SEED_Q    = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [WORD_W-1:0] SEED_QROT = 64'h7f4a_7c15_9e37_79b9;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t seed;
		word_t key;
	} mix_in_t;

	typedef struct packed {
		word_t a;
		word_t b;
	} mix_out_t;

endpackage

FILE: hw/rtl/bcks64_mix.sv
module bcks64_mix (
	input  bcks64_pkg::mix_in_t  mix_in,
	output bcks64_pkg::mix_out_t mix_out
);

	bcks64_pkg::word_t sum_seed;
	bcks64_pkg::word_t a_new;
	bcks64_pkg::word_t sum_ab;
	bcks64_pkg::word_t sum_key;
	logic [2*bcks64_pkg::WORD_W-1:0] rot_wide;
	logic [bcks64_pkg::ROT_W-1:0] amt;

	assign sum_seed = mix_in.seed + mix_in.a + mix_in.b;
	assign a_new    = {sum_seed[bcks64_pkg::WORD_W-bcks64_pkg::FIXED_ROT-1:0],
		sum_seed[bcks64_pkg::WORD_W-1:bcks64_pkg::WORD_W-bcks64_pkg::FIXED_ROT]};
	assign sum_ab   = a_new + mix_in.b;
	assign sum_key  = mix_in.key + sum_ab;
	assign amt      = sum_ab[bcks64_pkg::ROT_W-1:0];
	// rotate left by amt: upper half of the doubled word shifted
	assign rot_wide = {sum_key, sum_key} << amt;

	assign mix_out.a = a_new;
	assign mix_out.b = rot_wide[2*bcks64_pkg::WORD_W-1:bcks64_pkg::WORD_W];

endmodule

FILE: hw/rtl/block_cipher_key_schedule_64_unit.sv
// Channel  Dir  Beat content
// s_*      in   one 128-bit key (two words)
// m_*      out  one subkey with its index; tlast on the final one
//
// One key gives 2*ROUNDS+2 beats (26 at twelve rounds), one per cycle from the shared
// mix unit while m_tready keeps up; s_tready drops for that run.
// A full output register with m_tready low holds the sequencer in place.
// arst_n clears the sequencer and the output valid; data registers keep contents.
module block_cipher_key_schedule_64_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bcks64_pkg::S_DATA_W-1:0]   s_tdata,  // key_first_word, key_second_word
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bcks64_pkg::M_DATA_W-1:0]   m_tdata,  // subkey_index, subkey_value, zero pad
	output logic                              m_tlast   // is_last
);

	logic busy_q;
	logic m_valid_q;
	logic [bcks64_pkg::IDX_W-1:0] idx_q;
	bcks64_pkg::word_t a_q, b_q, seed_q, key_q, key2_q;
	logic [bcks64_pkg::IDX_W-1:0] out_idx_q;
	bcks64_pkg::word_t out_value_q;
	logic out_last_q;

	logic s_fire;
	logic step;
	logic last;
	bcks64_pkg::mix_in_t  mix_in;
	bcks64_pkg::mix_out_t mix_out;

	assign s_tready = !busy_q;
	assign s_fire   = s_tvalid && s_tready;
	assign step     = busy_q && (!m_valid_q || m_tready);
	assign last     = (idx_q == bcks64_pkg::LAST_IDX);

	assign mix_in.a    = a_q;
	assign mix_in.b    = b_q;
	assign mix_in.seed = seed_q;
	assign mix_in.key  = key_q;

	bcks64_mix u_mix (
		.mix_in  (mix_in),
		.mix_out (mix_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			m_valid_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (s_fire) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (step) begin
				idx_q <= idx_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (step) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			a_q    <= '0;
			b_q    <= '0;
			seed_q <= bcks64_pkg::SEED_P;
			key_q  <= s_tdata[bcks64_pkg::WORD_W-1:0];
			key2_q <= s_tdata[bcks64_pkg::S_DATA_W-1:bcks64_pkg::WORD_W];
		end else if (step && !last) begin
			a_q    <= mix_out.a;
			b_q    <= mix_out.b;
			seed_q <= seed_q + bcks64_pkg::SEED_QROT;
			key_q  <= (idx_q == '0) ? key2_q : key_q + bcks64_pkg::SEED_Q;
		end
		if (step) begin
			out_idx_q   <= idx_q;
			out_value_q <= last ? seed_q : mix_out.a;
			out_last_q  <= last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{bcks64_pkg::M_PAD_W{1'b0}}, out_value_q, out_idx_q};
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready)
		else $error("key accepted while a run is in progress");

	a_step_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_tvalid && (m_tdata[bcks64_pkg::IDX_W-1:0] == $past(idx_q)))
		else $error("sequencer step did not present its subkey");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[bcks64_pkg::IDX_W-1:0] == bcks64_pkg::LAST_IDX)
		else $error("tlast on a subkey other than the final one");

	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> s_tready)
		else $error("input not released after the final subkey");
`endif

endmodule

FILE: tb/block_cipher_key_schedule_64_unit_test.sv
`timescale 1ns / 1ps

module block_cipher_key_schedule_64_unit_test;
	import bcks64_pkg::*;

	localparam int unsigned RANDOM_KEYS = 300;
	localparam int unsigned STALL_LIMIT = 4000;

	typedef struct {
		logic [IDX_W-1:0] idx;
		word_t            value;
		logic             last;
	} subkey_t;

	class subkey_board;
		subkey_t expected_subkeys[$];
		int      mismatches = 0;

		function word_t rotl(word_t v, logic [ROT_W-1:0] r);
			return (r == 0) ? v : ((v << r) | (v >> (WORD_W - r)));
		endfunction

		function void note_key(word_t k0, word_t k1);
			word_t   a;
			word_t   b;
			word_t   seed;
			word_t   key;
			word_t   value;
			subkey_t s;
			a = '0;
			b = '0;
			for (int j = 0; j < NUM_SUBKEYS; j++) begin
				seed = SEED_P + word_t'(j) * SEED_QROT;
				if (j == NUM_SUBKEYS - 1) begin
					value = seed;
				end else begin
					key   = (j == 0) ? k0 : k1 + word_t'(j - 1) * SEED_Q;
					value = rotl(seed + a + b, ROT_W'(FIXED_ROT));
					a     = value;
					b     = rotl(key + a + b, ROT_W'(a + b));
				end
				s.idx   = IDX_W'(j);
				s.value = value;
				s.last  = (j == NUM_SUBKEYS - 1);
				expected_subkeys.push_back(s);
			end
		endfunction

		task report(string what, word_t got, word_t want);
			$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_subkey(logic [IDX_W-1:0] idx, word_t value, logic last);
			subkey_t s;
			if (expected_subkeys.size() == 0) begin
				report("unexpected beat, index", word_t'(idx), '0);
			end else begin
				s = expected_subkeys.pop_front();
				if (idx !== s.idx)
					report("subkey index", word_t'(idx), word_t'(s.idx));
				if (value !== s.value)
					report("subkey value", value, s.value);
				if (last !== s.last)
					report("last flag", word_t'(last), word_t'(s.last));
			end
		endtask

		function int pending();
			return expected_subkeys.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	subkey_board board;
	logic        calm;
	int          idle_cycles;

	block_cipher_key_schedule_64_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	// sink stalls, switched off during the calm stretch
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 15);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_subkey(m_tdata[IDX_W-1:0], m_tdata[IDX_W +: WORD_W], m_tlast);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("block_cipher_key_schedule_64_unit regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function word_t random_word();
		return {$urandom, $urandom};
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_key(word_t k0, word_t k1);
		if (!calm) begin
			while ($urandom_range(99) < 15) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {k1, k0};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_key(k0, k1);
		@(negedge clk);
	endtask

	initial begin
		board       = new;
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		calm        = 1'b0;
		idle_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_key('0, '0);
		send_key('1, '1);
		send_key('1, '0);
		send_key('0, '1);
		send_key({32{2'b01}}, {32{2'b10}});
		send_key({32{2'b10}}, {32{2'b01}});
		send_key(64'd1, 64'h8000_0000_0000_0000);
		send_key(64'h8000_0000_0000_0000, 64'd1);
		send_key(-SEED_Q, SEED_Q);
		send_key(SEED_P, SEED_QROT);

		for (int n = 0; n < RANDOM_KEYS; n++) begin
			calm = (n >= 120 && n < 180);
			send_key(random_word(), random_word());
		end
		calm     = 1'b0;
		s_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (NUM_SUBKEYS + 8) @(posedge clk);

		if (board.mismatches == 0 && board.pending() == 0)
			$display("block_cipher_key_schedule_64_unit regression: pass");
		else
			$display("block_cipher_key_schedule_64_unit regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/bcks64_pkg.sv
hw/rtl/bcks64_mix.sv
hw/rtl/block_cipher_key_schedule_64_unit.sv
tb/block_cipher_key_schedule_64_unit_test.sv
